// File: sv/flc_pkg.sv
// ============================================================================
// flc_pkg: shared types and constants for the FIR linear convolution block
// Holds the sequencer state type, control bundles between the sequencer,
// the tap memories and the MAC unit, and the fixed field widths.
// ============================================================================
package flc_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 16;               // Q1.15 sample / coefficient
    localparam int PROD_W    = 2 * SAMPLE_W;     // exact Q2.30 product
    localparam int OUT_W     = 36;               // Q6.30 output
    localparam int TAP_CNT_W = 5;                // tap_count register
    localparam int IDX_W     = 4;                // tap_index field

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = TAP_CNT_W'(16);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Input action codes
    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic wr_en;    // write one entry and mark it valid
        logic inv_en;   // mark the write-address entry as zero
        logic clr_all;  // mark every entry as zero
        logic rd_en;    // registered read
    } t_mem_ctl;

    typedef struct packed {
        logic clr;      // zero the accumulator
        logic vld;      // operands valid this cycle
    } t_mac_ctl;

endpackage

// File: sv/flc_tap_mem.sv
// ============================================================================
// flc_tap_mem: tap storage with per-entry valid bits
// Single write port, single registered read port. An entry that is not
// valid reads as zero, so reset and bulk clear need no sweep.
// ============================================================================
module flc_tap_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  flc_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [WIDTH-1:0]   i_wr_data,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [WIDTH-1:0]   o_rd_data
);
    import flc_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            priority if (i_ctl.clr_all) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_ctl.inv_en) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
            if (i_ctl.rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

// File: sv/flc_mac.sv
// ============================================================================
// flc_mac: shared multiply-accumulate unit
// Register the exact product, then add it into a wide accumulator.
// ============================================================================
module flc_mac #(
    parameter int ACC_W = 37
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  flc_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [flc_pkg::SAMPLE_W-1:0] i_coef,
    input  logic signed [flc_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [ACC_W-1:0]             o_acc,
    output logic                                o_busy
);
    import flc_pkg::*;

    logic                     r_p_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_p_vld <= i_ctl.vld;
            priority if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_p_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_p_vld;

endmodule

// File: sv/fir_linear_convolution_top.sv
// ============================================================================
// fir_linear_convolution_top: direct-form FIR, full linear convolution
// Sequencer, circular delay line, coefficient store and one shared MAC.
// ============================================================================
// Each input beat is either a coefficient load (action 0) or a signal sample
// (action 1). A load writes coefficient tap_index (ignored when tap_index >=
// TAPS) and produces nothing. A sample enters the delay line
// and produces one output beat: the exact sum over the taps in use of
// coefficient[j] * history[j], a Q6.30 value saturated to 36 bits (it can
// only saturate when TAPS is large). A sample marked last_sample is followed
// by tap_count-1 tail outputs computed with zeros shifted in, the final one
// flagged last_output, after which the delay line is cleared. Each output is
// computed by the single multiply-accumulate unit, which visits one tap per
// clock; the read, product and accumulate stages then drain, and the result
// is loaded into the output register.
// The input is not ready while a sample and its tail are being worked;
// a finished output waits in the output register without stalling the next
// accept. tap_count is taken from the config channel (always ready); 0 acts
// as 1 and values above TAPS act as TAPS. Coefficient loads apply at once.
// After reset both stores read as zero at once: no clearing pass is needed.
module fir_linear_convolution_top #(
    parameter int TAPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write channel (tap_count)
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [flc_pkg::TAP_CNT_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_action,
    input  logic [flc_pkg::IDX_W-1:0]            i_tap_index,
    input  logic signed [flc_pkg::SAMPLE_W-1:0]  i_value,
    input  logic                                 i_last_sample,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [flc_pkg::OUT_W-1:0]     o_out_value,
    output logic                                 o_last_output
);
    import flc_pkg::*;

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW    = $clog2(TAPS + 1);
    localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
    localparam int EXT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W;

    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(OUT_MAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(OUT_MIN);

    // Sequencer state
    t_state                r_state, n_state;
    logic [TAP_CNT_W-1:0]  r_tap_count;
    logic [AW-1:0]         r_wp, n_wp;          // newest sample slot
    logic [AW-1:0]         r_rd_ptr, n_rd_ptr;  // history slot for tap r_j
    logic [CW-1:0]         r_j, n_j;            // tap being issued
    logic [CW-1:0]         r_n, n_n;            // taps in use for this item
    logic [CW-1:0]         r_tail, n_tail;      // tail outputs still owed
    logic                  r_last, n_last;
    logic                  r_rd_vld;            // memory read data valid

    // Output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_value;
    logic                    r_out_last;

    logic                    w_in_acc;
    logic                    w_idx_ok;
    logic                    w_out_load;
    logic [CW-1:0]           w_n_eff;
    logic [AW-1:0]           w_wp_inc;
    logic [AW-1:0]           w_rd_dec;
    t_mem_ctl                w_coef_ctl;
    t_mem_ctl                w_hist_ctl;
    t_mac_ctl                w_mac_ctl;
    logic [SAMPLE_W-1:0]     w_coef_rd;
    logic [SAMPLE_W-1:0]     w_hist_rd;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_mac_busy;
    logic signed [EXT_W-1:0] w_acc_ext;
    logic signed [OUT_W-1:0] w_sat;

    // ------------------------------------------------------------------
    // Config: always take the write beat
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_tap_count <= i_cfg_data;
        end
    end

    // Clamp tap_count into 1..TAPS
    always_comb begin
        priority if (r_tap_count == '0) begin
            w_n_eff = CW'(1);
        end else if (int'(r_tap_count) > TAPS) begin
            w_n_eff = CW'(TAPS);
        end else begin
            w_n_eff = CW'(r_tap_count);
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and circular pointer arithmetic
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_idx_ok   = int'(i_tap_index) < TAPS;
    assign w_out_load = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    assign w_wp_inc = (r_wp == AW'(TAPS - 1)) ? '0 : r_wp + AW'(1);
    assign w_rd_dec = (r_rd_ptr == '0) ? AW'(TAPS - 1) : r_rd_ptr - AW'(1);

    // ------------------------------------------------------------------
    // Next state and control
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_rd_ptr   = r_rd_ptr;
        n_j        = r_j;
        n_n        = r_n;
        n_tail     = r_tail;
        n_last     = r_last;
        w_coef_ctl = '0;
        w_hist_ctl = '0;
        w_mac_ctl  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_action == ACTION_LOAD) begin
                        w_coef_ctl.wr_en = w_idx_ok;
                    end else begin
                        // Shift the sample in and start the first output
                        w_hist_ctl.wr_en = 1'b1;
                        w_mac_ctl.clr    = 1'b1;
                        n_wp             = w_wp_inc;
                        n_rd_ptr         = w_wp_inc;
                        n_j              = '0;
                        n_n              = w_n_eff;
                        n_last           = i_last_sample;
                        n_tail           = i_last_sample ? w_n_eff - CW'(1) : '0;
                        n_state          = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                // Issue one tap per cycle, walking back through the history
                w_coef_ctl.rd_en = 1'b1;
                w_hist_ctl.rd_en = 1'b1;
                n_j              = r_j + CW'(1);
                n_rd_ptr         = w_rd_dec;
                if (r_j == r_n - CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // Wait for the read and product stages to empty
                if (!r_rd_vld && !w_mac_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_load) begin
                    if (r_tail != '0) begin
                        // Shift a zero in and compute the next tail output
                        w_hist_ctl.inv_en = 1'b1;
                        w_mac_ctl.clr     = 1'b1;
                        n_wp              = w_wp_inc;
                        n_rd_ptr          = w_wp_inc;
                        n_j               = '0;
                        n_tail            = r_tail - CW'(1);
                        n_state           = ST_MAC;
                    end else begin
                        // No tail output owed; at the end of the signal, drop the whole delay line
                        w_hist_ctl.clr_all = r_last;
                        n_state            = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        w_mac_ctl.vld = r_rd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_rd_ptr <= '0;
            r_j      <= '0;
            r_n      <= CW'(1);
            r_tail   <= '0;
            r_last   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_rd_ptr <= n_rd_ptr;
            r_j      <= n_j;
            r_n      <= n_n;
            r_tail   <= n_tail;
            r_last   <= n_last;
            r_rd_vld <= w_hist_ctl.rd_en;
        end
    end

    // ------------------------------------------------------------------
    // Storage and the shared MAC
    // ------------------------------------------------------------------
    flc_tap_mem #(
        .DEPTH (TAPS),
        .WIDTH (SAMPLE_W)
    ) u_coef_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_coef_ctl),
        .i_wr_addr (AW'(i_tap_index)),
        .i_wr_data (i_value),
        .i_rd_addr (r_j[AW-1:0]),
        .o_rd_data (w_coef_rd)
    );

    flc_tap_mem #(
        .DEPTH (TAPS),
        .WIDTH (SAMPLE_W)
    ) u_hist_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_hist_ctl),
        .i_wr_addr (w_wp_inc),
        .i_wr_data (i_value),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_hist_rd)
    );

    flc_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_coef   (w_coef_rd),
        .i_sample (w_hist_rd),
        .o_acc    (w_acc),
        .o_busy   (w_mac_busy)
    );

    // ------------------------------------------------------------------
    // Saturate into the 36-bit output and hold it until taken
    // ------------------------------------------------------------------
    assign w_acc_ext = EXT_W'(w_acc);

    always_comb begin
        priority if (w_acc_ext > SAT_HI) begin
            w_sat = OUT_MAX;
        end else if (w_acc_ext < SAT_LO) begin
            w_sat = OUT_MIN;
        end else begin
            w_sat = w_acc_ext[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value <= w_sat;
            r_out_last  <= r_last && (r_tail == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_last_output = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_j < r_n))
        else $error("tap counter ran past the taps in use");

    a_drain_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_j == r_n))
        else $error("drain entered before every tap was issued");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail < r_n))
        else $error("tail count exceeds taps in use");

    a_ready_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_rd_vld && !w_mac_busy))
        else $error("input ready while the MAC pipeline is still busy");

endmodule
